>>> src/ascii_can_frame_parser_macros.svh
// Assertion macros for the ASCII CAN frame parser.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef ASCII_CAN_FRAME_PARSER_MACROS_SVH
`define ASCII_CAN_FRAME_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACFP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("acfp check failed");

// The consequent must hold in the cycle after the antecedent.
`define ACFP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("acfp check failed");

`endif

>>> src/acfp_pkg.sv
// Shared types, codes and the hex digit decoder of the ASCII CAN frame parser.
// No dependencies.
package acfp_pkg;

   // Parse phases.
   localparam logic [3:0] PH_ID          = 4'd0;
   localparam logic [3:0] PH_AFTER_DELIM = 4'd1;
   localparam logic [3:0] PH_REMOTE_LEN  = 4'd2;
   localparam logic [3:0] PH_REMOTE_DONE = 4'd3;
   localparam logic [3:0] PH_FD_FLAGS    = 4'd4;
   localparam logic [3:0] PH_DATA_START  = 4'd5;
   localparam logic [3:0] PH_DATA_DOT    = 4'd6;
   localparam logic [3:0] PH_DATA_HIGH   = 4'd7;
   localparam logic [3:0] PH_FULL        = 4'd8;

   // Characters with a meaning of their own.
   localparam logic [7:0] CHAR_DELIM  = 8'h23;  // '#'
   localparam logic [7:0] CHAR_DOT    = 8'h2E;  // '.'
   localparam logic [7:0] CHAR_R_UP   = 8'h52;  // 'R'
   localparam logic [7:0] CHAR_R_LOW  = 8'h72;  // 'r'
   localparam logic [7:0] CHAR_0      = 8'h30;
   localparam logic [7:0] CHAR_A_UP   = 8'h41;
   localparam logic [7:0] CHAR_A_LOW  = 8'h61;

   // Delimiter positions for standard and extended identifiers.
   localparam logic [7:0] POS_STD_DELIM = 8'd3;
   localparam logic [7:0] POS_EXT_DELIM = 8'd8;
   localparam logic [7:0] POS_MAX       = 8'd255;

   // Flag bits in the identifier word.
   localparam int EFF_BIT = 31;
   localparam int RTR_BIT = 30;
   localparam int ERR_BIT = 29;

   // Largest valid remote length code.
   localparam logic [4:0] REMOTE_LEN_MAX = 5'd8;

   // Result kinds and status codes.
   localparam logic       KIND_BYTE      = 1'b0;
   localparam logic       KIND_SUMMARY   = 1'b1;
   localparam logic [1:0] STATUS_ERROR   = 2'd0;
   localparam logic [1:0] STATUS_CLASSIC = 2'd1;
   localparam logic [1:0] STATUS_FD      = 2'd2;

   // Result queue geometry.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic        kind;
      logic [5:0]  byte_index;
      logic [7:0]  byte_value;
      logic [31:0] frame_id;
      logic [3:0]  fd_flags;
      logic [6:0]  length;
      logic [1:0]  status;
      logic        final_res;
   } rsp_type;

   // Results produced by one character: zero, one or two.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   // Queue status seen by the top level.
   typedef struct packed {
      logic              room;
      logic [QCNT_W-1:0] level;
   } qstat_type;

   // Hex digit value; bit 4 set means the character is no hex digit.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'h10;
      if (c inside {[8'h30:8'h39]}) begin
         v = 5'(c - CHAR_0);
      end else if (c inside {[8'h41:8'h46]}) begin
         v = 5'(c - CHAR_A_UP) + 5'd10;
      end else if (c inside {[8'h61:8'h66]}) begin
         v = 5'(c - CHAR_A_LOW) + 5'd10;
      end
      return v;
   endfunction

endpackage

>>> src/acfp_parser.sv
// Character parser: frame state registers and the per-character update.
// Depends on acfp_pkg.
module acfp_parser
   import acfp_pkg::*;
#(
   parameter int CLASSIC_MAX_BYTES = 8,
   parameter int FD_MAX_BYTES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] ch,
   input  logic       last,
   output push_type   push
);

   logic [7:0]  pos_ff, pos_in;
   logic [3:0]  phase_ff, phase_in;
   logic [31:0] id_ff, id_in;
   logic        fd_ff, fd_in;
   logic [3:0]  flags_ff, flags_in;
   logic [6:0]  bcount_ff, bcount_in;
   logic [3:0]  hi_ff, hi_in;
   logic        err_ff, err_in;
   logic [3:0]  rlen_ff, rlen_in;

   logic [4:0] v;
   logic [6:0] bcount_inc;
   logic [6:0] limit;
   logic       data_go;
   logic       emit;
   logic       bad;
   rsp_type    byte_res;
   rsp_type    sum_res;

   assign v = hex_value(ch);
   assign bcount_inc = bcount_ff + 7'd1;
   assign limit = fd_ff ? 7'(FD_MAX_BYTES) : 7'(CLASSIC_MAX_BYTES);

   always_comb begin
      pos_in = pos_ff;
      phase_in = phase_ff;
      id_in = id_ff;
      fd_in = fd_ff;
      flags_in = flags_ff;
      bcount_in = bcount_ff;
      hi_in = hi_ff;
      err_in = err_ff;
      rlen_in = rlen_ff;
      data_go = 1'b0;
      emit = 1'b0;

      if (!err_ff) begin
         case (phase_ff)
            PH_ID: begin
               if ((pos_ff == POS_STD_DELIM || pos_ff == POS_EXT_DELIM) &&
                   ch == CHAR_DELIM) begin
                  if (pos_ff == POS_EXT_DELIM && !id_ff[ERR_BIT]) begin
                     id_in[EFF_BIT] = 1'b1;
                  end
                  phase_in = PH_AFTER_DELIM;
               end else if (pos_ff >= POS_EXT_DELIM || v[4]) begin
                  err_in = 1'b1;
               end else begin
                  id_in = {id_ff[27:0], v[3:0]};
               end
            end
            PH_AFTER_DELIM: begin
               if (ch == CHAR_R_UP || ch == CHAR_R_LOW) begin
                  id_in[RTR_BIT] = 1'b1;
                  phase_in = PH_REMOTE_LEN;
               end else if (ch == CHAR_DELIM) begin
                  fd_in = 1'b1;
                  phase_in = PH_FD_FLAGS;
               end else begin
                  phase_in = PH_DATA_START;
                  data_go = 1'b1;
               end
            end
            PH_REMOTE_LEN: begin
               if (v <= REMOTE_LEN_MAX) begin
                  rlen_in = v[3:0];
               end
               phase_in = PH_REMOTE_DONE;
            end
            PH_FD_FLAGS: begin
               if (v[4]) begin
                  err_in = 1'b1;
               end else begin
                  flags_in = v[3:0];
                  phase_in = PH_DATA_START;
               end
            end
            PH_DATA_START, PH_DATA_DOT, PH_DATA_HIGH: begin
               data_go = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // Data byte digits; a byte begins in the start phase or right after the delimiter, where one dot may come first.
      if (data_go) begin
         if ((phase_ff == PH_DATA_START || phase_ff == PH_AFTER_DELIM) &&
             ch == CHAR_DOT) begin
            phase_in = PH_DATA_DOT;
         end else if (v[4]) begin
            err_in = 1'b1;
         end else if (phase_ff != PH_DATA_HIGH) begin
            hi_in = v[3:0];
            phase_in = PH_DATA_HIGH;
         end else begin
            emit = 1'b1;
            bcount_in = bcount_inc;
            phase_in = (bcount_inc >= limit) ? PH_FULL : PH_DATA_START;
         end
      end

      if (pos_ff != POS_MAX) begin
         pos_in = pos_ff + 8'd1;
      end

      // Summary from the updated state.
      bad = err_in || phase_in == PH_ID || phase_in == PH_FD_FLAGS ||
            phase_in == PH_DATA_HIGH;
      sum_res = '0;
      sum_res.kind = KIND_SUMMARY;
      sum_res.final_res = 1'b1;
      if (!bad) begin
         sum_res.frame_id = id_in;
         if (phase_in == PH_REMOTE_LEN || phase_in == PH_REMOTE_DONE) begin
            sum_res.length = {3'd0, rlen_in};
            sum_res.status = STATUS_CLASSIC;
         end else begin
            sum_res.fd_flags = fd_in ? flags_in : 4'd0;
            sum_res.length = bcount_in;
            sum_res.status = fd_in ? STATUS_FD : STATUS_CLASSIC;
         end
      end

      // The frame ends here: everything returns to its reset value.
      if (last) begin
         pos_in = '0;
         phase_in = PH_ID;
         id_in = '0;
         fd_in = 1'b0;
         flags_in = '0;
         bcount_in = '0;
         hi_in = '0;
         err_in = 1'b0;
         rlen_in = '0;
      end
   end

   always_comb begin
      byte_res = '0;
      byte_res.kind = KIND_BYTE;
      byte_res.byte_index = bcount_ff[5:0];
      byte_res.byte_value = {hi_ff, v[3:0]};
      byte_res.final_res = !last;

      push.second = sum_res;
      if (emit) begin
         push.first = byte_res;
         push.count = last ? 2'd2 : 2'd1;
      end else begin
         push.first = sum_res;
         push.count = last ? 2'd1 : 2'd0;
      end
      if (!accept) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         phase_ff <= PH_ID;
         id_ff <= '0;
         fd_ff <= 1'b0;
         flags_ff <= '0;
         bcount_ff <= '0;
         hi_ff <= '0;
         err_ff <= 1'b0;
         rlen_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         phase_ff <= phase_in;
         id_ff <= id_in;
         fd_ff <= fd_in;
         flags_ff <= flags_in;
         bcount_ff <= bcount_in;
         hi_ff <= hi_in;
         err_ff <= err_in;
         rlen_ff <= rlen_in;
      end
   end

endmodule

>>> src/acfp_rsp_queue.sv
// Result queue: takes up to two results a cycle, hands out one a cycle when it is popped.
// Depends on acfp_pkg.
module acfp_rsp_queue
   import acfp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   input  logic      pop,
   output logic      head_valid,
   output rsp_type   head,
   output qstat_type stat
);

   rsp_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QPTR_W-1:0] wr_ptr_next;
   logic              do_pop;

   assign do_pop = pop && head_valid;
   assign wr_ptr_next = wr_ptr_ff + QPTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(do_pop);
   assign count_in = count_ff + QCNT_W'(push.count) - QCNT_W'(do_pop);

   assign head_valid = count_ff != '0;
   assign head = entry_ff[rd_ptr_ff];
   // Room means at least two free entries, enough for the most one character can cause.
   assign stat.room = count_ff <= QCNT_W'(QDEPTH - 2);
   assign stat.level = count_ff;

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> src/ascii_can_frame_parser.sv
// Top level of the ASCII CAN frame parser: the character parser and its result queue.
// Depends on acfp_pkg, acfp_parser, acfp_rsp_queue and the assertion macro header.
`include "ascii_can_frame_parser_macros.svh"

// This block reads CAN frame text in the "id#data" notation one character per item
// and takes a new character in every clock cycle unless req_stall is high. Each
// character is handled in the cycle it is accepted: the frame state registers
// update and the results it causes are written into a four-entry result queue,
// whose head drives the rsp_ ports. A character that completes a data byte yields
// a data byte item; the character marked last yields a summary item after it, so
// one character may cause two items. The input stalls whenever fewer than two
// queue entries are free, which means a waiting consumer stalls the input once
// three or four items are queued, and a steady stream of characters keeps one
// item per cycle as long as the consumer takes one item per cycle. When a summary
// reports an error status, the data bytes already delivered for that frame are to be
// dropped.
module ascii_can_frame_parser
   import acfp_pkg::*;
#(
   parameter int CLASSIC_MAX_BYTES = 8,
   parameter int FD_MAX_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [5:0]  rsp_byte_index,
   output logic [7:0]  rsp_byte_value,
   output logic [31:0] rsp_frame_id,
   output logic [3:0]  rsp_fd_flags,
   output logic [6:0]  rsp_length,
   output logic [1:0]  rsp_status,
   output logic        rsp_final_res
);

   logic      req_accept;
   push_type  push;
   rsp_type   head;
   qstat_type qstat;

   // The stall depends only on queue occupancy, never on the incoming valid.
   assign req_stall = !qstat.room;
   assign req_accept = req_valid && !req_stall;

   acfp_parser #(
      .CLASSIC_MAX_BYTES(CLASSIC_MAX_BYTES),
      .FD_MAX_BYTES(FD_MAX_BYTES)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .accept(req_accept),
      .ch(req_ch),
      .last(req_last),
      .push(push)
   );

   acfp_rsp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .pop(!rsp_stall),
      .head_valid(rsp_valid),
      .head(head),
      .stat(qstat)
   );

   assign rsp_kind = head.kind;
   assign rsp_byte_index = head.byte_index;
   assign rsp_byte_value = head.byte_value;
   assign rsp_frame_id = head.frame_id;
   assign rsp_fd_flags = head.fd_flags;
   assign rsp_length = head.length;
   assign rsp_status = head.status;
   assign rsp_final_res = head.final_res;

   // Results are only ever produced by an accepted character.
   `ACFP_ASSERT_NOW(a_push_needs_accept, push.count != 2'd0, req_accept)
   // The last character of a frame always queues at least its summary.
   `ACFP_ASSERT_NOW(a_last_gives_summary, req_accept && req_last, push.count != 2'd0)
   // A summary is always the final item of its character.
   `ACFP_ASSERT_NOW(a_summary_final, rsp_valid && rsp_kind == KIND_SUMMARY, rsp_final_res)
   // The queue never holds more than its depth.
   `ACFP_ASSERT_NEXT(a_queue_bound, 1'b1, qstat.level <= QCNT_W'(QDEPTH))

endmodule
